// ===== rtl/vmt_pkg.sv =====
// ----------------------------------------------------------------------------
// vmt_pkg: virtio-mmio transport register file definitions
// Transaction payload types, opcodes, window layout and status bits shared by
// the register file and its top level.
// ----------------------------------------------------------------------------
package vmt_pkg;

  // Request opcodes
  localparam logic [1:0] OpRead       = 2'd0;
  localparam logic [1:0] OpWrite      = 2'd1;
  localparam logic [1:0] OpCompletion = 2'd2;

  // Window layout
  localparam int unsigned DeviceCount    = 2;
  localparam int unsigned QueueSizeLimit = 64;
  localparam int unsigned WinSize        = 'h200;
  localparam logic [63:0] WindowBase     = 64'hD000_0000;
  localparam logic [63:0] WindowSpan     = 64'(WinSize * DeviceCount);
  localparam logic [8:0]  CfgStart       = 9'h100;

  // Identity and feature values
  localparam logic [31:0] MagicValue   = 32'h7472_6976;
  localparam logic [31:0] VendorValue  = 32'h554E_4F00;
  localparam logic [31:0] RoFeature    = 32'h0000_0020;
  localparam logic [31:0] Ver1Feature  = 32'h0000_0001;

  // Device status bits
  localparam int unsigned StDriverOkBit   = 2;
  localparam int unsigned StFeaturesOkBit = 3;

  // Configuration port
  localparam int unsigned CfgAddrW      = 4;
  localparam int unsigned CfgDataW      = 64;
  localparam int unsigned DiskSectorsW  = 55;
  localparam logic        RegDiskSectors = 1'b0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] address;
    logic [31:0] write_data;
    logic        completion_device;
  } req_t;

  typedef struct packed {
    logic        handled;
    logic [31:0] read_data;
    logic        notify_valid;
    logic        notify_device;
    logic        notify_queue;
    logic [6:0]  notify_queue_size;
    logic [63:0] notify_desc_addr;
    logic [63:0] notify_avail_addr;
    logic [63:0] notify_used_addr;
    logic        irq_line_console;
    logic        irq_line_block;
  } rsp_t;

endpackage

// ===== rtl/vmt_regfile.sv =====
// ----------------------------------------------------------------------------
// vmt_regfile: per-device and per-queue transport registers
// Decodes one registered request against the device windows, forms its
// response and updates the register state when the request is taken.
// ----------------------------------------------------------------------------
module vmt_regfile (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 fire_i,
  input  vmt_pkg::req_t                        req_i,
  input  logic [vmt_pkg::DiskSectorsW-1:0]     disk_sectors_i,
  output vmt_pkg::rsp_t                        rsp_o
);

  localparam logic [8:0] OffMagic      = 9'h000;
  localparam logic [8:0] OffVersion    = 9'h004;
  localparam logic [8:0] OffDeviceId   = 9'h008;
  localparam logic [8:0] OffVendorId   = 9'h00C;
  localparam logic [8:0] OffDevFeat    = 9'h010;
  localparam logic [8:0] OffDevFeatSel = 9'h014;
  localparam logic [8:0] OffDrvFeat    = 9'h020;
  localparam logic [8:0] OffDrvFeatSel = 9'h024;
  localparam logic [8:0] OffQueueSel   = 9'h030;
  localparam logic [8:0] OffQueueMax   = 9'h034;
  localparam logic [8:0] OffQueueNum   = 9'h038;
  localparam logic [8:0] OffQueueReady = 9'h044;
  localparam logic [8:0] OffQueueNtfy  = 9'h050;
  localparam logic [8:0] OffIntStatus  = 9'h060;
  localparam logic [8:0] OffIntAck     = 9'h064;
  localparam logic [8:0] OffStatus     = 9'h070;
  localparam logic [8:0] OffDescLo     = 9'h080;
  localparam logic [8:0] OffDescHi     = 9'h084;
  localparam logic [8:0] OffAvailLo    = 9'h090;
  localparam logic [8:0] OffAvailHi    = 9'h094;
  localparam logic [8:0] OffUsedLo     = 9'h0A0;
  localparam logic [8:0] OffUsedHi     = 9'h0A4;
  localparam logic [8:0] OffCapLo      = 9'h100;
  localparam logic [8:0] OffCapHi      = 9'h104;

  logic [31:0] status_q    [2];
  logic [31:0] status_d    [2];
  logic [31:0] int_stat_q  [2];
  logic [31:0] int_stat_d  [2];
  logic        ver1_q      [2];
  logic        ver1_d      [2];
  logic        offer_hi_q  [2];
  logic        offer_hi_d  [2];
  logic        accept_hi_q [2];
  logic        accept_hi_d [2];
  logic        qsel_q      [2];
  logic        qsel_d      [2];
  logic [6:0]  entries_q   [4];
  logic [6:0]  entries_d   [4];
  logic [31:0] ready_q     [4];
  logic [31:0] ready_d     [4];
  logic [63:0] desc_q      [4];
  logic [63:0] desc_d      [4];
  logic [63:0] avail_q     [4];
  logic [63:0] avail_d     [4];
  logic [63:0] used_q      [4];
  logic [63:0] used_d      [4];

  logic [63:0] rel;
  logic        in_win;
  logic        dev;
  logic [8:0]  off;
  logic [1:0]  qi;
  logic [1:0]  nq;
  logic [31:0] wdata;
  logic [31:0] new_status;
  logic [31:0] rd_data;

  assign rel    = req_i.address - vmt_pkg::WindowBase;
  assign in_win = (req_i.address >= vmt_pkg::WindowBase) && (rel < vmt_pkg::WindowSpan);
  assign dev    = rel[9];
  assign off    = rel[8:0];
  assign qi     = {dev, qsel_q[dev]};
  assign nq     = {dev, req_i.write_data[0]};
  assign wdata  = req_i.write_data;

  // Register read mux
  always_comb begin
    rd_data = '0;
    if (off >= vmt_pkg::CfgStart) begin
      if (dev) begin
        if (off == OffCapLo) begin
          rd_data = disk_sectors_i[31:0];
        end else if (off == OffCapHi) begin
          rd_data = 32'(disk_sectors_i[vmt_pkg::DiskSectorsW-1:32]);
        end
      end
    end else begin
      unique case (off)
        OffMagic:      rd_data = vmt_pkg::MagicValue;
        OffVersion:    rd_data = 32'd2;
        OffDeviceId:   rd_data = dev ? 32'd2 : 32'd3;
        OffVendorId:   rd_data = vmt_pkg::VendorValue;
        OffDevFeat: begin
          if (offer_hi_q[dev]) begin
            rd_data = vmt_pkg::Ver1Feature;
          end else begin
            rd_data = dev ? vmt_pkg::RoFeature : 32'd0;
          end
        end
        OffQueueMax:   rd_data = 32'(vmt_pkg::QueueSizeLimit);
        OffQueueReady: rd_data = ready_q[qi];
        OffIntStatus:  rd_data = int_stat_q[dev];
        OffStatus:     rd_data = status_q[dev];
        default:       rd_data = '0;
      endcase
    end
  end

  // Drop the features-accepted status bit unless VERSION_1 was accepted
  always_comb begin
    new_status = wdata;
    if (wdata[vmt_pkg::StFeaturesOkBit] && !ver1_q[dev]) begin
      new_status[vmt_pkg::StFeaturesOkBit] = 1'b0;
    end
  end

  always_comb begin
    rsp_o       = '0;
    status_d    = status_q;
    int_stat_d  = int_stat_q;
    ver1_d      = ver1_q;
    offer_hi_d  = offer_hi_q;
    accept_hi_d = accept_hi_q;
    qsel_d      = qsel_q;
    entries_d   = entries_q;
    ready_d     = ready_q;
    desc_d      = desc_q;
    avail_d     = avail_q;
    used_d      = used_q;

    if (req_i.opcode == vmt_pkg::OpCompletion) begin
      rsp_o.handled = 1'b1;
      if (int'(req_i.completion_device) < vmt_pkg::DeviceCount) begin
        int_stat_d[req_i.completion_device][0] = 1'b1;
      end
    end else if ((req_i.opcode == vmt_pkg::OpRead || req_i.opcode == vmt_pkg::OpWrite)
                 && in_win) begin
      rsp_o.handled = 1'b1;
      if (req_i.opcode == vmt_pkg::OpRead) begin
        rsp_o.read_data = rd_data;
      end else if (off < vmt_pkg::CfgStart) begin
        unique case (off)
          OffDevFeatSel: offer_hi_d[dev]  = (wdata != '0);
          OffDrvFeatSel: accept_hi_d[dev] = (wdata != '0);
          OffDrvFeat: begin
            if (accept_hi_q[dev]) begin
              ver1_d[dev] = wdata[0];
            end
          end
          OffQueueSel: qsel_d[dev] = (wdata < 32'd2) ? wdata[0] : 1'b0;
          OffQueueNum: begin
            entries_d[qi] = (wdata > 32'(vmt_pkg::QueueSizeLimit))
                          ? 7'(vmt_pkg::QueueSizeLimit) : wdata[6:0];
          end
          OffQueueReady: ready_d[qi] = wdata;
          OffQueueNtfy: begin
            if (wdata < 32'd2 && entries_q[nq] != '0) begin
              rsp_o.notify_valid      = 1'b1;
              rsp_o.notify_device     = dev;
              rsp_o.notify_queue      = wdata[0];
              rsp_o.notify_queue_size = entries_q[nq];
              rsp_o.notify_desc_addr  = desc_q[nq];
              rsp_o.notify_avail_addr = avail_q[nq];
              rsp_o.notify_used_addr  = used_q[nq];
            end
          end
          OffIntAck: int_stat_d[dev] = int_stat_q[dev] & ~wdata;
          OffStatus: begin
            status_d[dev] = new_status;
            // Reset the device: clear its queues, interrupts and features
            if (new_status == '0) begin
              for (int q = 0; q < 4; q++) begin
                if (q[1] == dev) begin
                  entries_d[q] = '0;
                  ready_d[q]   = '0;
                  desc_d[q]    = '0;
                  avail_d[q]   = '0;
                  used_d[q]    = '0;
                end
              end
              int_stat_d[dev] = '0;
              ver1_d[dev]     = 1'b0;
            end
          end
          OffDescLo:  desc_d[qi][31:0]   = wdata;
          OffDescHi:  desc_d[qi][63:32]  = wdata;
          OffAvailLo: avail_d[qi][31:0]  = wdata;
          OffAvailHi: avail_d[qi][63:32] = wdata;
          OffUsedLo:  used_d[qi][31:0]   = wdata;
          OffUsedHi:  used_d[qi][63:32]  = wdata;
          default: ;
        endcase
      end
    end

    // Interrupt levels after this transaction's update
    rsp_o.irq_line_console = (0 < vmt_pkg::DeviceCount) && (int_stat_d[0] != '0)
                           && status_d[0][vmt_pkg::StDriverOkBit];
    rsp_o.irq_line_block   = (1 < vmt_pkg::DeviceCount) && (int_stat_d[1] != '0)
                           && status_d[1][vmt_pkg::StDriverOkBit];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < 2; d++) begin
        status_q[d]    <= '0;
        int_stat_q[d]  <= '0;
        ver1_q[d]      <= 1'b0;
        offer_hi_q[d]  <= 1'b0;
        accept_hi_q[d] <= 1'b0;
        qsel_q[d]      <= 1'b0;
      end
      for (int q = 0; q < 4; q++) begin
        entries_q[q] <= '0;
        ready_q[q]   <= '0;
        desc_q[q]    <= '0;
        avail_q[q]   <= '0;
        used_q[q]    <= '0;
      end
    end else if (fire_i) begin
      status_q    <= status_d;
      int_stat_q  <= int_stat_d;
      ver1_q      <= ver1_d;
      offer_hi_q  <= offer_hi_d;
      accept_hi_q <= accept_hi_d;
      qsel_q      <= qsel_d;
      entries_q   <= entries_d;
      ready_q     <= ready_d;
      desc_q      <= desc_d;
      avail_q     <= avail_d;
      used_q      <= used_d;
    end
  end

`ifndef SYNTH
  a_entries_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entries_q[0] <= 7'(vmt_pkg::QueueSizeLimit) && entries_q[1] <= 7'(vmt_pkg::QueueSizeLimit)
    && entries_q[2] <= 7'(vmt_pkg::QueueSizeLimit)
    && entries_q[3] <= 7'(vmt_pkg::QueueSizeLimit))
    else $error("queue size above limit");

  a_notify_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && rsp_o.notify_valid |-> rsp_o.notify_queue_size != '0)
    else $error("notify for an empty queue");

  a_unhandled_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !rsp_o.handled |-> rsp_o.read_data == '0 && !rsp_o.notify_valid)
    else $error("unhandled transaction carries data");

  a_irq_console_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && rsp_o.irq_line_console |=>
      int_stat_q[0] != '0 && status_q[0][vmt_pkg::StDriverOkBit])
    else $error("console interrupt level disagrees with state");
`endif

endmodule

// ===== rtl/virtio_mmio_transport_regs_unit.sv =====
// ----------------------------------------------------------------------------
// virtio_mmio_transport_regs_unit: virtio-mmio transport register block
// Version-2 transport registers for a console and a read-only block disk.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (read, write, completion) arrive on the in_* valid/ready channel
//   and each produces exactly one response on the out_* channel, carrying
//   read data, a doorbell event and both interrupt levels.
//   A request is captured in an input register, decoded and applied to the
//   register state as it moves on, and its response lands in the output
//   register.
//   Throughput is one transaction per cycle while the receiver takes responses;
//   the single decode-and-update stage between the input and output registers
//   sets that figure. When the receiver stalls, the response holds and the
//   input register holds one more request; in_ready_o drops only when both are full.
//   The disk capacity is written over the APB port (64-bit data, paddr[3] = 0);
//   the user writes it only while no transaction is in flight (not enforced).
//   Reset clears all transport registers, both valid flags and the capacity.
// ----------------------------------------------------------------------------
module virtio_mmio_transport_regs_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  vmt_pkg::req_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output vmt_pkg::rsp_t                     out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vmt_pkg::CfgAddrW-1:0]      paddr,
  input  logic [vmt_pkg::CfgDataW-1:0]      pwdata,
  output logic [vmt_pkg::CfgDataW-1:0]      prdata,
  output logic                              pready
);

  logic                              req_valid_q;
  vmt_pkg::req_t                     req_q;
  logic                              out_valid_q;
  vmt_pkg::rsp_t                     out_q;
  vmt_pkg::rsp_t                     rsp;
  logic [vmt_pkg::DiskSectorsW-1:0]  disk_sectors_q;
  logic                              advance;
  logic                              fire;
  logic                              cfg_hit;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = req_valid_q && advance;
  assign in_ready_o = !req_valid_q || advance;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[3] == vmt_pkg::RegDiskSectors);
  assign prdata  = cfg_hit ? vmt_pkg::CfgDataW'(disk_sectors_q) : '0;

  vmt_regfile u_regfile (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .req_i          (req_q),
    .disk_sectors_i (disk_sectors_q),
    .rsp_o          (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q    <= 1'b0;
      out_valid_q    <= 1'b0;
      disk_sectors_q <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        req_valid_q <= 1'b1;
      end else if (fire) begin
        req_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (psel && penable && pwrite && pready && cfg_hit) begin
        disk_sectors_q <= pwdata[vmt_pkg::DiskSectorsW-1:0];
      end
    end
  end

  // Payload registers: load on transaction, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
    if (fire) begin
      out_q <= rsp;
    end
  end

endmodule
